// File: rtl/akc_pkg.sv
// Shared types and constants for the autokey text cipher.
package akc_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned SHIFT_W  = 5;

    localparam logic [COUNT_W-1:0] DIGIT_SPAN = 4'd10;
    localparam logic [SHIFT_W-1:0] ALPHA_SPAN = 5'd26;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd9;

    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7A;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic advance;
        logic mode;
    } ctrl_t;

endpackage

// File: rtl/akc_core.sv
// Cipher state registers and the per-word transform.
module akc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  akc_pkg::ctrl_t              ctrl,
    input  logic [akc_pkg::CHAR_W-1:0]  in_char,
    input  logic                        new_message,
    output logic [akc_pkg::CHAR_W-1:0]  out_char
);
    import akc_pkg::*;

    logic [COUNT_W-1:0] digit_count_reg, digit_count_next;
    logic               prev_is_letter_reg, prev_is_letter_next;
    logic [SHIFT_W-1:0] prev_shift_reg, prev_shift_next;

    logic [COUNT_W-1:0] eff_count;
    logic               eff_is_letter;
    logic [SHIFT_W-1:0] eff_shift;
    logic               is_digit, is_upper, is_lower, is_letter, decoding;
    logic [COUNT_W-1:0] dpos, dres;
    logic [COUNT_W:0]   dsum;
    logic [SHIFT_W-1:0] lpos, lres;
    logic [SHIFT_W:0]   lsum;
    logic [CHAR_W-1:0]  base, lbase_off;

    always_comb
    begin
        decoding      = (ctrl.mode == MODE_DECODE);
        eff_count     = new_message ? '0 : digit_count_reg;
        eff_is_letter = new_message ? 1'b0 : prev_is_letter_reg;
        eff_shift     = new_message ? '0 : prev_shift_reg;

        is_digit  = (in_char >= CHAR_0) && (in_char <= CHAR_9);
        is_upper  = (in_char >= CHAR_UP_A) && (in_char <= CHAR_UP_Z);
        is_lower  = (in_char >= CHAR_LOW_A) && (in_char <= CHAR_LOW_Z);
        is_letter = is_upper || is_lower;

        dpos = in_char[COUNT_W-1:0];
        if (decoding)
        begin
            if (dpos >= eff_count)
                dsum = {1'b0, dpos} - {1'b0, eff_count};
            else
                dsum = {1'b0, dpos} + {1'b0, DIGIT_SPAN} - {1'b0, eff_count};
        end
        else
        begin
            dsum = {1'b0, dpos} + {1'b0, eff_count};
            if (dsum >= {1'b0, DIGIT_SPAN})
                dsum = dsum - {1'b0, DIGIT_SPAN};
        end
        dres = dsum[COUNT_W-1:0];

        base      = is_upper ? CHAR_UP_A : CHAR_LOW_A;
        lbase_off = in_char - base;
        lpos      = lbase_off[SHIFT_W-1:0];
        if (!eff_is_letter)
            lsum = {1'b0, lpos};
        else if (decoding)
        begin
            if (lpos >= eff_shift)
                lsum = {1'b0, lpos} - {1'b0, eff_shift};
            else
                lsum = {1'b0, lpos} + {1'b0, ALPHA_SPAN} - {1'b0, eff_shift};
        end
        else
        begin
            lsum = {1'b0, lpos} + {1'b0, eff_shift};
            if (lsum >= {1'b0, ALPHA_SPAN})
                lsum = lsum - {1'b0, ALPHA_SPAN};
        end
        lres = lsum[SHIFT_W-1:0];

        if (is_digit)
            out_char = CHAR_0 + {{(CHAR_W-COUNT_W){1'b0}}, dres};
        else if (is_letter)
            out_char = base + {{(CHAR_W-SHIFT_W){1'b0}}, lres};
        else
            out_char = in_char;

        if (is_digit)
            digit_count_next = (eff_count == COUNT_MAX) ? '0 : eff_count + 1'b1;
        else
            digit_count_next = eff_count;
        prev_is_letter_next = is_letter;
        if (is_letter)
            prev_shift_next = decoding ? lres : lpos;
        else
            prev_shift_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg    <= '0;
            prev_is_letter_reg <= 1'b0;
            prev_shift_reg     <= '0;
        end
        else if (ctrl.advance)
        begin
            digit_count_reg    <= digit_count_next;
            prev_is_letter_reg <= prev_is_letter_next;
            prev_shift_reg     <= prev_shift_next;
        end
    end

endmodule

// File: rtl/autokey_text_cipher.sv
// Top level of the autokey text cipher with its stream handshake and mode register.
// A word is held in the input register and moves into the result register when it advances.
// Throughput: one word per cycle while the sink keeps taking results; an empty input
// register takes a new word while a finished one waits for the sink.
// Reset: rst_n clears the mode to encode, the digit count and the letter chain,
// and empties both registers; no clearing pass is needed.
module autokey_text_cipher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,      // mode: 0 encode, 1 decode
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [akc_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] in_char
    input  logic                        s_axis_tuser,   // [0] new_message
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [akc_pkg::CHAR_W-1:0]  m_axis_tdata    // [7:0] out_char
);
    import akc_pkg::*;

    logic              mode_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              new_msg_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CHAR_W-1:0] out_char_next;
    logic              advance;
    ctrl_t             ctrl;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign ctrl.advance  = advance;
    assign ctrl.mode     = mode_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;

    akc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .in_char     (in_char_reg),
        .new_message (new_msg_reg),
        .out_char    (out_char_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_ENCODE;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            new_msg_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_char_reg <= out_char_next;
    end

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("Result register not loaded after a word advanced.");

    a_held_input_stable: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg)
            && $stable(new_msg_reg))
        else $error("Stalled input register changed.");

    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("Input stalled without a full pipeline.");

endmodule

// File: tb/akc_checker.sv
// Checker for the autokey text cipher: watches both streams, predicts each output word and compares.
`timescale 1ns / 100ps

module akc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [akc_pkg::CHAR_W-1:0] s_axis_tdata,
    input  logic                       s_axis_tuser,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [akc_pkg::CHAR_W-1:0] m_axis_tdata,
    output int                         mismatch_count,
    output int                         pending_words
);
    import akc_pkg::*;

    logic [CHAR_W-1:0]  expected_chars[$];
    logic               cipher_mode;
    logic [COUNT_W-1:0] digit_count;
    logic               chain_live;
    logic [SHIFT_W-1:0] chain_key;
    int                 errors = 0;

    task automatic encipher_char(input logic [CHAR_W-1:0] c, input logic fresh);
        int                pos;
        int                base;
        logic [CHAR_W-1:0] res;
        logic [CHAR_W-1:0] plain;
        if (fresh)
        begin
            digit_count = '0;
            chain_live  = 1'b0;
            chain_key   = '0;
        end
        res = c;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            pos = c - CHAR_0;
            if (cipher_mode == MODE_DECODE)
                pos = (pos + DIGIT_SPAN - digit_count) % DIGIT_SPAN;
            else
                pos = (pos + digit_count) % DIGIT_SPAN;
            res = CHAR_0 + CHAR_W'(pos);
            digit_count = (digit_count == COUNT_MAX) ? '0 : digit_count + 1'b1;
        end
        else if ((c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LOW_A && c <= CHAR_LOW_Z))
        begin
            base = (c <= CHAR_UP_Z) ? CHAR_UP_A : CHAR_LOW_A;
            if (chain_live)
            begin
                pos = c - base;
                if (cipher_mode == MODE_DECODE)
                    pos = (pos + ALPHA_SPAN - chain_key) % ALPHA_SPAN;
                else
                    pos = (pos + chain_key) % ALPHA_SPAN;
                res = CHAR_W'(base + pos);
            end
        end
        // The key always comes from the plaintext side of the stream.
        plain = (cipher_mode == MODE_DECODE) ? res : c;
        if (plain >= CHAR_UP_A && plain <= CHAR_UP_Z)
        begin
            chain_live = 1'b1;
            chain_key  = SHIFT_W'(plain - CHAR_UP_A);
        end
        else if (plain >= CHAR_LOW_A && plain <= CHAR_LOW_Z)
        begin
            chain_live = 1'b1;
            chain_key  = SHIFT_W'(plain - CHAR_LOW_A);
        end
        else
        begin
            chain_live = 1'b0;
            chain_key  = '0;
        end
        expected_chars.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [CHAR_W-1:0] want;
        if (!rst_n)
        begin
            expected_chars.delete();
            cipher_mode = MODE_ENCODE;
            digit_count = '0;
            chain_live  = 1'b0;
            chain_key   = '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output word, expected none, actual %02h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        errors++;
                        $display("%0t: out_char mismatch, expected %02h, actual %02h",
                                 $time, want, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                encipher_char(s_axis_tdata, s_axis_tuser);
            if (cfg_we)
                cipher_mode = cfg_wdata;
        end
        mismatch_count <= errors;
        pending_words  <= expected_chars.size();
    end

endmodule

// File: tb/tb_autokey_text_cipher.sv
// Testbench top for the autokey text cipher: clock, reset, stimulus, sink pacing and verdict.
`timescale 1ns / 100ps

module tb_autokey_text_cipher;
    import akc_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 160;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              cfg_we        = 1'b0;
    logic              cfg_wdata     = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CHAR_W-1:0] m_axis_tdata;

    int mismatch_count;
    int pending_words;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit long_hold_req = 1'b0;

    autokey_text_cipher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    akc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic fresh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= fresh;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
    endtask

    task automatic send_text(input string s, input logic fresh);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], fresh && (i == 0));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
        @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input logic m,
                             input bit with_hold);
        int                kind;
        logic [CHAR_W-1:0] c;
        drain();
        write_mode(m);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            if (with_hold && i == 20)
                long_hold_req = 1'b1;
            kind = $urandom_range(99);
            if (kind < 40)
                c = CHAR_LOW_A + CHAR_W'($urandom_range(25));
            else if (kind < 60)
                c = CHAR_UP_A + CHAR_W'($urandom_range(25));
            else if (kind < 75)
                c = CHAR_0 + CHAR_W'($urandom_range(9));
            else if (kind < 85)
                c = 8'h20 + CHAR_W'($urandom_range(94));
            else
                c = CHAR_W'($urandom_range(255));
            send_char(c, $urandom_range(99) < 3);
        end
    endtask

    initial
    begin : sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Letter chain with wrap and case changes, then bytes outside the alphabet.
        send_text("Az9YYza", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_text("@[{", 1'b0);
        send_char(8'h60, 1'b0);
        drain();

        // Switch to decoding mid-message; the digit count runs past nine.
        write_mode(MODE_DECODE);
        send_text("/1234567890:", 1'b0);
        send_text("Qb", 1'b1);

        run_phase(0, 0, MODE_ENCODE, 1'b1);
        run_phase(0, 0, MODE_DECODE, 1'b0);
        run_phase(66, 0, MODE_ENCODE, 1'b0);
        run_phase(66, 0, MODE_DECODE, 1'b0);
        run_phase(0, 66, MODE_DECODE, 1'b0);
        run_phase(0, 66, MODE_ENCODE, 1'b0);
        run_phase(27, 27, MODE_DECODE, 1'b0);
        run_phase(27, 27, MODE_ENCODE, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_words == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
